/* hw/rtl/emf_pkg.sv */
// ----------------------------------------------------------------------------
// emf_pkg
// Request and response types, the pi constant and the single-step helpers
// for the pipelined square root and divider.
// ----------------------------------------------------------------------------
package emf_pkg;

    typedef struct packed {
        logic signed [31:0] focus_one_x;
        logic signed [31:0] focus_one_y;
        logic signed [31:0] focus_two_x;
        logic signed [31:0] focus_two_y;
        logic        [31:0] major_length;
    } ellipse_req_t;

    typedef struct packed {
        logic        is_valid;
        logic [31:0] focal_half;
        logic [30:0] semi_minor;
        logic [47:0] area_value;
        logic [33:0] perimeter;
    } ellipse_rsp_t;

    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [35:0] den;
        logic [30:0] quo;
    } div_t;

    function automatic sqrt_t sqrt_step(input sqrt_t s);
        sqrt_t       o;
        logic [35:0] acc;
        logic [35:0] trial;
        acc   = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[61:0], 2'b00};
        if (acc >= trial) begin
            o.rem  = 34'(acc - trial);
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = acc[33:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic div_t div_step(input div_t d, input logic shift);
        div_t        o;
        logic [35:0] acc;
        acc   = shift ? {d.rem[34:0], 1'b0} : d.rem;
        o.den = d.den;
        if (acc >= d.den) begin
            o.rem = acc - d.den;
            o.quo = {d.quo[29:0], 1'b1};
        end else begin
            o.rem = acc;
            o.quo = {d.quo[29:0], 1'b0};
        end
        return o;
    endfunction

endpackage

/* hw/rtl/ellipse_metrics_from_foci.sv */
// ----------------------------------------------------------------------------
// ellipse_metrics_from_foci
// Ellipse metrics from two foci and the major axis length.
// ----------------------------------------------------------------------------
// Input channel s_: one request per ellipse, two signed Q16.16 foci and the
// unsigned Q16.16 full major axis. Output channel m_: one response per
// request, in order: validity, half focal distance, semi-minor axis, area and
// Ramanujan circumference.
// Datapath: 139 register stages (pipelined 32-step square roots, two
// pipelined 31-step dividers, split multipliers), then the output register.
// Throughput: one request per cycle while the skid register is empty.
// Stall: a full output register parks the next response in a skid register;
// while the skid register is full the whole datapath holds and s_ready is low.
// Nothing is dropped or repeated.
// Reset: aresetn low for one edge empties the datapath and both output
// registers; s_ready is high after reset.
// ----------------------------------------------------------------------------
module ellipse_metrics_from_foci import emf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  ellipse_req_t s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output ellipse_rsp_t m_data
);

    logic         core_valid;
    ellipse_rsp_t core_data;
    logic         out_v_reg, skid_v_reg;
    ellipse_rsp_t out_reg, skid_reg;
    logic         en;

    assign en      = !skid_v_reg;
    assign s_ready = en;

    emf_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .out_valid(core_valid),
        .out_data (core_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_ready) begin
            if (skid_v_reg) begin
                out_reg    <= skid_reg;
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_reg   <= core_data;
                out_v_reg <= core_valid;
            end
        end else if (core_valid && !skid_v_reg) begin
            skid_reg   <= core_data;
            skid_v_reg <= 1'b1;
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid register full while output register empty");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_v_reg && !m_ready) |=> skid_v_reg)
        else $error("skid register lost a response during stall");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_valid) |-> (m_data.semi_minor == '0 &&
            m_data.area_value == '0 && m_data.perimeter == '0))
        else $error("invalid ellipse with nonzero metrics");
`endif

endmodule

/* hw/rtl/emf_core.sv */
// ----------------------------------------------------------------------------
// emf_core
// Fixed-depth datapath: half focal distance, semi-minor axis, area and
// circumference, one request per cycle while enabled.
// ----------------------------------------------------------------------------
module emf_core import emf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  ellipse_req_t in_data,
    output logic         out_valid,
    output ellipse_rsp_t out_data
);

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;
    localparam int NSTAGE    = 13 + 2 * SQ_STEPS + 2 * DIV_STEPS;

    typedef struct packed {
        logic        ok;
        logic [31:0] c;
        logic [30:0] b;
        logic [47:0] area;
        logic [32:0] s;
    } side_t;

    logic [NSTAGE-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NSTAGE-1];

    // front: differences, squares, validity, focal and semi-minor square roots
    logic signed [32:0] dx, dy;
    logic [31:0] ax_reg, ay_reg, l0_reg;
    logic [63:0] sx_reg, sy_reg, l2_reg;
    logic [31:0] l1_reg;
    logic [64:0] lo_sum;

    assign dx = {in_data.focus_one_x[31], in_data.focus_one_x}
              - {in_data.focus_two_x[31], in_data.focus_two_x};
    assign dy = {in_data.focus_one_y[31], in_data.focus_one_y}
              - {in_data.focus_two_y[31], in_data.focus_two_y};
    assign lo_sum = {1'b0, sx_reg} + {1'b0, sy_reg};

    sqrt_t       sc_reg  [0:SQ_STEPS];
    sqrt_t       sb_reg  [0:SQ_STEPS];
    logic [31:0] sl_reg  [0:SQ_STEPS];
    logic        sok_reg [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= dx[32] ? 32'(-dx) : dx[31:0];
            ay_reg <= dy[32] ? 32'(-dy) : dy[31:0];
            l0_reg <= in_data.major_length;
            sx_reg <= 64'(ax_reg) * 64'(ax_reg);
            sy_reg <= 64'(ay_reg) * 64'(ay_reg);
            l2_reg <= 64'(l0_reg) * 64'(l0_reg);
            l1_reg <= l0_reg;
            sc_reg[0].rad  <= {1'b0, lo_sum[64:2]};
            sc_reg[0].rem  <= '0;
            sc_reg[0].root <= '0;
            sb_reg[0].rad  <= (l2_reg - lo_sum[63:0]) >> 2;
            sb_reg[0].rem  <= '0;
            sb_reg[0].root <= '0;
            sl_reg[0]  <= l1_reg;
            sok_reg[0] <= (l1_reg != '0) && !lo_sum[64] && (l2_reg > lo_sum[63:0]);
            for (int i = 1; i <= SQ_STEPS; i++) begin
                sc_reg[i]  <= sqrt_step(sc_reg[i-1]);
                sb_reg[i]  <= sqrt_step(sb_reg[i-1]);
                sl_reg[i]  <= sl_reg[i-1];
                sok_reg[i] <= sok_reg[i-1];
            end
        end
    end

    // axis products, area and axis ratio divider
    logic [30:0] b_root;
    logic [31:0] l_cur;
    logic [62:0] m_lb_reg;
    logic [32:0] m_s_reg, m_d_reg, a_s_reg, a_d_reg;
    logic [31:0] m_c_reg, a_c_reg;
    logic [30:0] m_b_reg, a_b_reg;
    logic        m_ok_reg, a_ok_reg;
    logic [63:0] a_lo_reg, a_hi_reg, a_u;

    assign b_root = sb_reg[SQ_STEPS].root[30:0];
    assign l_cur  = sl_reg[SQ_STEPS];
    assign a_u    = a_hi_reg + (a_lo_reg >> 32);

    div_t  dv_reg  [0:DIV_STEPS];
    side_t sd1_reg [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            m_lb_reg <= 63'(l_cur) * 63'(b_root);
            m_s_reg  <= {1'b0, l_cur} + {1'b0, b_root, 1'b0};
            m_d_reg  <= {1'b0, l_cur} - {1'b0, b_root, 1'b0};
            m_c_reg  <= sc_reg[SQ_STEPS].root;
            m_b_reg  <= b_root;
            m_ok_reg <= sok_reg[SQ_STEPS];
            a_lo_reg <= 64'(m_lb_reg[31:0]) * 64'(PI_Q30);
            a_hi_reg <= 64'(m_lb_reg[62:32]) * 64'(PI_Q30);
            a_s_reg  <= m_s_reg;
            a_d_reg  <= m_d_reg;
            a_c_reg  <= m_c_reg;
            a_b_reg  <= m_b_reg;
            a_ok_reg <= m_ok_reg;
            dv_reg[0].rem   <= 36'(a_d_reg);
            dv_reg[0].den   <= 36'(a_s_reg);
            dv_reg[0].quo   <= '0;
            sd1_reg[0].ok   <= a_ok_reg;
            sd1_reg[0].c    <= a_c_reg;
            sd1_reg[0].b    <= a_b_reg;
            sd1_reg[0].area <= 48'(a_u >> 15);
            sd1_reg[0].s    <= a_s_reg;
            for (int i = 1; i <= DIV_STEPS; i++) begin
                dv_reg[i]  <= div_step(dv_reg[i-1], i != 1);
                sd1_reg[i] <= sd1_reg[i-1];
            end
        end
    end

    // ratio square and inner root
    logic [61:0] rr;
    logic [30:0] h_reg;
    side_t       h_sd_reg;
    logic [32:0] h3;
    logic [32:0] h_diff;

    assign rr     = 62'(dv_reg[DIV_STEPS].quo) * 62'(dv_reg[DIV_STEPS].quo);
    assign h3     = {1'b0, h_reg, 1'b0} + {2'b00, h_reg};
    assign h_diff = 33'h1_0000_0000 - h3;

    sqrt_t       sq_reg  [0:SQ_STEPS];
    logic [32:0] n_reg   [0:SQ_STEPS];
    side_t       sd2_reg [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            h_reg    <= rr[60:30];
            h_sd_reg <= sd1_reg[DIV_STEPS];
            sq_reg[0].rad  <= {1'b0, h_diff, 30'd0};
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
            n_reg[0]   <= h3;
            sd2_reg[0] <= h_sd_reg;
            for (int i = 1; i <= SQ_STEPS; i++) begin
                sq_reg[i]  <= sqrt_step(sq_reg[i-1]);
                n_reg[i]   <= n_reg[i-1];
                sd2_reg[i] <= sd2_reg[i-1];
            end
        end
    end

    // correction term
    div_t  dw_reg  [0:DIV_STEPS];
    side_t sd3_reg [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            dw_reg[0].rem <= 36'(n_reg[SQ_STEPS]);
            dw_reg[0].den <= 36'd10737418240 + 36'(sq_reg[SQ_STEPS].root);
            dw_reg[0].quo <= '0;
            sd3_reg[0]    <= sd2_reg[SQ_STEPS];
            for (int i = 1; i <= DIV_STEPS; i++) begin
                dw_reg[i]  <= div_step(dw_reg[i-1], i != 1);
                sd3_reg[i] <= sd3_reg[i-1];
            end
        end
    end

    // circumference and output
    logic [30:0] fac;
    logic [62:0] p_reg;
    logic [30:0] p_fac_reg;
    side_t       p_sd_reg, v_sd_reg, t_sd_reg;
    logic [63:0] v_reg, t_lo_reg, t_hi_reg, t_u;
    logic [33:0] per;
    ellipse_rsp_t res_reg;

    assign fac = 31'h4000_0000 + dw_reg[DIV_STEPS].quo;
    assign t_u = t_hi_reg + (t_lo_reg >> 32);
    assign per = 34'(t_u >> 29);

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg     <= 63'(sd3_reg[DIV_STEPS].s[31:0]) * 63'(fac);
            p_fac_reg <= fac;
            p_sd_reg  <= sd3_reg[DIV_STEPS];
            v_reg     <= {1'b0, p_reg}
                       + (p_sd_reg.s[32] ? {1'b0, p_fac_reg, 32'd0} : 64'd0);
            v_sd_reg  <= p_sd_reg;
            t_lo_reg  <= 64'(v_reg[31:0]) * 64'(PI_Q30);
            t_hi_reg  <= 64'(v_reg[63:32]) * 64'(PI_Q30);
            t_sd_reg  <= v_sd_reg;
            res_reg.is_valid   <= t_sd_reg.ok;
            res_reg.focal_half <= t_sd_reg.c;
            res_reg.semi_minor <= t_sd_reg.ok ? t_sd_reg.b : '0;
            res_reg.area_value <= t_sd_reg.ok ? t_sd_reg.area : '0;
            res_reg.perimeter  <= t_sd_reg.ok ? per : '0;
        end
    end

    assign out_data = res_reg;

endmodule

/* tb/ellipse_metrics_from_foci_tb.sv */
// ----------------------------------------------------------------------------
// ellipse_metrics_from_foci_tb
// Self-checking bench for the ellipse metrics block: directed and random
// ellipses are driven through valid/ready under several idle/stall phases,
// and every response is compared field by field with an in-bench predictor.
// ----------------------------------------------------------------------------
module ellipse_metrics_from_foci_tb import emf_pkg::*;;

    localparam longint unsigned PI_Q30_U = 64'd3373259426;
    localparam int LATENCY = 140;
    localparam longint CYCLE_LIMIT = 600000;

    logic         aclk;
    logic         aresetn;
    logic         s_valid;
    logic         s_ready;
    ellipse_req_t s_data;
    logic         m_valid;
    logic         m_ready;
    ellipse_rsp_t m_data;

    ellipse_req_t pending_reqs[$];
    ellipse_rsp_t expected_rsps[$];
    int  mismatches;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    bit  sender_paused;
    longint cycle_count;

    ellipse_metrics_from_foci dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic ellipse_rsp_t ellipse_metrics(input ellipse_req_t q);
        ellipse_rsp_t o;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [64:0] dist_sq;
        logic [63:0] len_sq;
        logic [63:0] semi;
        logic [127:0] wide;
        logic [63:0] s_sum;
        logic [63:0] d_dif;
        logic [63:0] ratio;
        logic [63:0] h;
        logic [63:0] qr;
        logic [63:0] frac;
        bit ok;
        dx = 64'($signed(q.focus_one_x)) - 64'($signed(q.focus_two_x));
        dy = 64'($signed(q.focus_one_y)) - 64'($signed(q.focus_two_y));
        if (dx[63]) dx = -dx;
        if (dy[63]) dy = -dy;
        dist_sq = 65'(dx * dx) + 65'(dy * dy);
        len_sq = 64'(q.major_length) * 64'(q.major_length);
        ok = (q.major_length != 0) && !dist_sq[64] && (len_sq > dist_sq[63:0]);
        o = '0;
        o.is_valid = ok;
        o.focal_half = 32'(floor_sqrt(dist_sq[64:2]));
        if (ok) begin
            semi = floor_sqrt((len_sq - dist_sq[63:0]) >> 2);
            wide = 128'(64'(q.major_length) * semi) * PI_Q30_U;
            o.semi_minor = semi[30:0];
            o.area_value = 48'(wide >> 47);
            s_sum = 64'(q.major_length) + 2 * semi;
            d_dif = 64'(q.major_length) - 2 * semi;
            ratio = (d_dif << 30) / s_sum;
            h = (ratio * ratio) >> 30;
            qr = floor_sqrt(((64'd4 << 30) - 3 * h) << 30);
            frac = ((3 * h) << 30) / ((64'd10 << 30) + qr);
            wide = 128'(s_sum * ((64'd1 << 30) + frac)) * PI_Q30_U;
            o.perimeter = 34'(wide >> 61);
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    task automatic queue_req(input logic [31:0] ax, input logic [31:0] ay,
                             input logic [31:0] bx, input logic [31:0] by,
                             input logic [31:0] len);
        ellipse_req_t q;
        q.focus_one_x = ax;
        q.focus_one_y = ay;
        q.focus_two_x = bx;
        q.focus_two_y = by;
        q.major_length = len;
        pending_reqs.push_back(q);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return 32'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
            default: return 32'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    task automatic queue_random(input int n);
        logic [31:0] ax, ay, bx, by, len;
        longint unsigned sep_sum;
        longint signed ddx, ddy;
        for (int i = 0; i < n; i++) begin
            ax = rand_coord();
            ay = rand_coord();
            if ($urandom_range(0, 3) == 0) begin
                bx = $urandom;
                by = $urandom;
            end else begin
                bx = ax + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                by = ay + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            end
            ddx = longint'($signed(ax)) - longint'($signed(bx));
            ddy = longint'($signed(ay)) - longint'($signed(by));
            if (ddx < 0) ddx = -ddx;
            if (ddy < 0) ddy = -ddy;
            sep_sum = ddx + ddy;
            case ($urandom_range(0, 9))
                0: len = $urandom;
                1: len = (sep_sum > 64'hFFFF_FFFF) ? $urandom :
                         32'(sep_sum) + $urandom_range(0, 3);
                2: len = $urandom_range(0, 16);
                default: len = (sep_sum >= 64'hFFFF_0000) ? $urandom :
                               32'(sep_sum) + $urandom_range(1, 32'hFFFF_FFFF - 32'(sep_sum));
            endcase
            queue_req(ax, ay, bx, by, len);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsps.push_back(ellipse_metrics(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && !sender_paused &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= pending_reqs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        ellipse_rsp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected response", 64'(m_data.focal_half), 64'd0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_data.is_valid !== want.is_valid)
                        report_mismatch("is_valid", 64'(m_data.is_valid),
                                        64'(want.is_valid));
                    if (m_data.focal_half !== want.focal_half)
                        report_mismatch("focal_half", 64'(m_data.focal_half),
                                        64'(want.focal_half));
                    if (m_data.semi_minor !== want.semi_minor)
                        report_mismatch("semi_minor", 64'(m_data.semi_minor),
                                        64'(want.semi_minor));
                    if (m_data.area_value !== want.area_value)
                        report_mismatch("area_value", 64'(m_data.area_value),
                                        64'(want.area_value));
                    if (m_data.perimeter !== want.perimeter)
                        report_mismatch("perimeter", 64'(m_data.perimeter),
                                        64'(want.perimeter));
                end
            end
            m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        while (pending_reqs.size() != 0 || s_valid || expected_rsps.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        sender_paused = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // corners: coincident foci, zero axis, extremes, boundary equality
        queue_req(0, 0, 0, 0, 32'h0001_0000);
        queue_req(0, 0, 0, 0, 0);
        queue_req(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'hFFFF_FFFF);
        queue_req(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_req(0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000);
        queue_req(0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0005_0001);
        queue_req(0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0004_FFFF);
        queue_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(0, 0, 0, 0, 1);
        queue_req(0, 0, 1, 0, 2);
        queue_req(0, 0, 1, 0, 1);
        queue_req(32'h1234_5678, 32'hEDCB_A987, 32'h1234_5678, 32'hEDCB_A987, 32'h8000_0000);
        queue_req(0, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF);
        queue_req(32'hFFF0_0000, 32'h0010_0000, 32'h0010_0000, 32'hFFF0_0000, 32'h0050_0000);
        queue_req(0, 0, 32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
        queue_random(235);
        drain();

        send_idle_pct = 81;
        queue_random(200);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 81;
        queue_random(200);
        drain();

        send_idle_pct = 6;
        recv_stall_pct = 6;
        queue_random(150);
        drain();

        // hold the receiver off long enough to back the pipeline up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(200);
        hold_off = 1'b1;
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
        sender_paused = 1'b1;
        while (expected_rsps.size() != 0 || s_valid) @(posedge aclk);
        sender_paused = 1'b0;
        drain();

        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* ellipse_metrics_from_foci.f */
hw/rtl/emf_pkg.sv
hw/rtl/emf_core.sv
hw/rtl/ellipse_metrics_from_foci.sv
tb/ellipse_metrics_from_foci_tb.sv
